// ===== rtl/ffipa_pkg.sv =====
`default_nettype none

package ffipa_pkg;

    localparam int POS_W       = 10;
    localparam int TAG_W       = 2;
    localparam int PLANE_OUT_W = 4;
    localparam int USED_OUT_W  = 5;
    localparam int WORD_BITS   = 64;
    localparam int BIT_IDX_W   = 6;
    localparam int WORD_IDX_W  = POS_W - BIT_IDX_W;

    typedef enum logic [1:0] {
        STATUS_PLACED    = 2'd0,
        STATUS_NO_ROOM   = 2'd1,
        STATUS_BAD_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TEST,
        ST_SCAN,
        ST_MARK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic    clear;
        logic    load;
        logic    next_plane;
        logic    scan_step;
        logic    mark_start;
        logic    mark_step;
        logic    emit;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic hit;
        logic free_last;
        logic chk_last;
        logic plane_last;
        logic out_free;
    } sts_t;

    // bits lo..hi set, lo <= hi
    function automatic logic [WORD_BITS-1:0] span_mask(
        input logic [BIT_IDX_W-1:0] lo,
        input logic [BIT_IDX_W-1:0] hi
    );
        logic [WORD_BITS-1:0] upper;
        logic [WORD_BITS-1:0] lower;
        upper = {WORD_BITS{1'b1}} >> (6'd63 - hi);
        lower = ({{(WORD_BITS-1){1'b0}}, 1'b1} << lo) - {{(WORD_BITS-1){1'b0}}, 1'b1};
        return upper & ~lower;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ffipa_ram.sv =====
`default_nettype none

module ffipa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/ffipa_ctrl.sv =====
`default_nettype none

module ffipa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire ffipa_pkg::sts_t sts,
    output ffipa_pkg::cmd_t     cmd
);

    ffipa_pkg::state_t  state_reg;
    ffipa_pkg::state_t  state_next;
    ffipa_pkg::status_t code_reg;
    ffipa_pkg::status_t code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffipa_pkg::ST_CLEAR;
            code_reg  <= ffipa_pkg::STATUS_PLACED;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        unique case (state_reg)
            ffipa_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ffipa_pkg::ST_IDLE;
                end
            end
            ffipa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ffipa_pkg::ST_TEST;
                end
            end
            ffipa_pkg::ST_TEST:
            begin
                if (sts.bad)
                begin
                    code_next  = ffipa_pkg::STATUS_BAD_RANGE;
                    state_next = ffipa_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = ffipa_pkg::ST_SCAN;
                end
            end
            ffipa_pkg::ST_SCAN:
            begin
                priority if (sts.hit)
                begin
                    if (sts.plane_last)
                    begin
                        code_next  = ffipa_pkg::STATUS_NO_ROOM;
                        state_next = ffipa_pkg::ST_RESULT;
                    end
                    else
                    begin
                        cmd.next_plane = 1'b1;
                    end
                end
                else if (sts.free_last)
                begin
                    cmd.mark_start = 1'b1;
                    state_next     = ffipa_pkg::ST_MARK;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ffipa_pkg::ST_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (sts.chk_last)
                begin
                    code_next  = ffipa_pkg::STATUS_PLACED;
                    state_next = ffipa_pkg::ST_RESULT;
                end
            end
            ffipa_pkg::ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ffipa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffipa_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ffipa_pkg::ST_IDLE);

    // marking only follows a plane found free
    a_mark_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffipa_pkg::ST_MARK |->
            $past(state_reg) == ffipa_pkg::ST_SCAN || $past(state_reg) == ffipa_pkg::ST_MARK)
        else $error("mark pass entered without a scan");

    a_placed_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffipa_pkg::ST_RESULT && $changed(state_reg)
            && code_reg == ffipa_pkg::STATUS_PLACED) |->
            $past(state_reg) == ffipa_pkg::ST_MARK)
        else $error("placed result without a mark pass");

endmodule

`default_nettype wire

// ===== rtl/ffipa_dp.sv =====
`default_nettype none

module ffipa_dp #(
    parameter int NUM_PLANES    = 16,
    parameter int NUM_POSITIONS = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ffipa_pkg::cmd_t                      cmd,
    output ffipa_pkg::sts_t                           sts,
    input  wire logic [ffipa_pkg::POS_W-1:0]          first_pos,
    input  wire logic [ffipa_pkg::POS_W-1:0]          end_pos,
    input  wire logic [ffipa_pkg::TAG_W-1:0]          strand_tag,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [ffipa_pkg::PLANE_OUT_W-1:0]         plane_index,
    output logic [1:0]                                status,
    output logic [ffipa_pkg::USED_OUT_W-1:0]          planes_in_use
);

    localparam int WPP       = (NUM_POSITIONS + ffipa_pkg::WORD_BITS - 1) / ffipa_pkg::WORD_BITS;
    localparam int OCC_DEPTH = NUM_PLANES * WPP;
    localparam int STR_DEPTH = NUM_PLANES * NUM_POSITIONS;
    localparam int OAW       = (OCC_DEPTH > 1) ? $clog2(OCC_DEPTH) : 1;
    localparam int SAW       = $clog2(STR_DEPTH);
    localparam int PW        = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int UW        = $clog2(NUM_PLANES + 1);
    localparam int PSW       = ffipa_pkg::POS_W;
    localparam int WIW       = ffipa_pkg::WORD_IDX_W;
    localparam int BIW       = ffipa_pkg::BIT_IDX_W;
    localparam logic [PSW-1:0] LAST_POS = PSW'(NUM_POSITIONS - 1);

    // item registers
    logic [PSW-1:0]                 start_reg;
    logic [PSW-1:0]                 end_reg;
    logic [ffipa_pkg::TAG_W-1:0]    tag_reg;
    logic                           bad_reg;
    logic [PW-1:0]                  plane_reg;
    logic [UW-1:0]                  used_reg;
    logic [UW-1:0]                  used_next;
    logic [SAW-1:0]                 clr_reg;

    // word scan pipeline: issue counter and the word whose data is on the RAM output
    logic [WIW:0]                   iss_w_reg;
    logic [WIW-1:0]                 chk_w_reg;
    logic                           chk_valid_reg;
    logic                           iss_more;

    logic                           out_valid_reg;
    logic [ffipa_pkg::PLANE_OUT_W-1:0] out_plane_reg;
    ffipa_pkg::status_t             out_status_reg;
    logic [ffipa_pkg::USED_OUT_W-1:0]  out_used_reg;

    logic [PSW-1:0]                 end_clip;
    logic                           in_bad;
    logic [BIW-1:0]                 lo;
    logic [BIW-1:0]                 hi;
    logic [ffipa_pkg::WORD_BITS-1:0] mask;
    logic                           overlap;

    logic                           occ_we;
    logic [OAW-1:0]                 occ_wr_addr;
    logic [ffipa_pkg::WORD_BITS-1:0] occ_wr_data;
    logic [OAW-1:0]                 occ_rd_addr;
    logic [ffipa_pkg::WORD_BITS-1:0] occ_rd_data;

    logic                           str_we;
    logic [SAW-1:0]                 str_wr_addr;
    logic [ffipa_pkg::TAG_W-1:0]    str_wr_data;
    logic [SAW-1:0]                 str_place_addr;
    logic [ffipa_pkg::TAG_W-1:0]    str_rd_data;

    assign end_clip = (32'(end_pos) >= NUM_POSITIONS) ? LAST_POS : end_pos;
    assign in_bad   = (first_pos > end_pos) || (32'(first_pos) >= NUM_POSITIONS);

    assign lo   = (chk_w_reg == start_reg[PSW-1:BIW]) ? start_reg[BIW-1:0] : '0;
    assign hi   = (chk_w_reg == end_reg[PSW-1:BIW]) ? end_reg[BIW-1:0] : {BIW{1'b1}};
    assign mask = ffipa_pkg::span_mask(lo, hi);
    assign overlap  = |(occ_rd_data & mask);
    assign iss_more = (iss_w_reg <= {1'b0, end_reg[PSW-1:BIW]});

    assign occ_rd_addr    = OAW'(plane_reg) * OAW'(WPP) + OAW'(iss_w_reg[WIW-1:0]);
    assign str_place_addr = SAW'(plane_reg) * SAW'(NUM_POSITIONS) + SAW'(start_reg);

    assign used_next = (UW'(plane_reg) >= used_reg) ? UW'(plane_reg) + UW'(1) : used_reg;

    always_comb
    begin
        occ_we      = 1'b0;
        occ_wr_addr = OAW'(plane_reg) * OAW'(WPP) + OAW'(chk_w_reg);
        occ_wr_data = occ_rd_data | mask;
        str_we      = 1'b0;
        str_wr_addr = str_place_addr;
        str_wr_data = tag_reg;
        if (cmd.clear)
        begin
            occ_we      = (32'(clr_reg) < OCC_DEPTH);
            occ_wr_addr = OAW'(clr_reg);
            occ_wr_data = '0;
            str_we      = 1'b1;
            str_wr_addr = clr_reg;
            str_wr_data = '0;
        end
        else if (cmd.mark_step)
        begin
            occ_we = chk_valid_reg;
        end
        else if (cmd.mark_start)
        begin
            str_we = 1'b1;
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.clr_last   = (clr_reg == SAW'(STR_DEPTH - 1));
        sts.bad        = bad_reg;
        sts.hit        = chk_valid_reg && overlap;
        sts.free_last  = chk_valid_reg && !overlap && (chk_w_reg == end_reg[PSW-1:BIW]);
        sts.chk_last   = chk_valid_reg && (chk_w_reg == end_reg[PSW-1:BIW]);
        sts.plane_last = (plane_reg == PW'(NUM_PLANES - 1));
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            used_reg      <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + SAW'(1);
            end
            if (cmd.mark_start)
            begin
                used_reg <= used_next;
            end
            if (cmd.scan_step || cmd.mark_step)
            begin
                chk_valid_reg <= iss_more;
            end
            else if (cmd.load || cmd.next_plane || cmd.mark_start)
            begin
                chk_valid_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_reg <= first_pos;
            end_reg   <= end_clip;
            tag_reg   <= strand_tag;
            bad_reg   <= in_bad;
            plane_reg <= '0;
            iss_w_reg <= {1'b0, first_pos[PSW-1:BIW]};
        end
        else if (cmd.next_plane)
        begin
            plane_reg <= plane_reg + PW'(1);
            iss_w_reg <= {1'b0, start_reg[PSW-1:BIW]};
        end
        else if (cmd.mark_start)
        begin
            iss_w_reg <= {1'b0, start_reg[PSW-1:BIW]};
        end
        else if ((cmd.scan_step || cmd.mark_step) && iss_more)
        begin
            chk_w_reg <= iss_w_reg[WIW-1:0];
            iss_w_reg <= iss_w_reg + (WIW+1)'(1);
        end
        if (cmd.emit)
        begin
            out_plane_reg  <= (cmd.code == ffipa_pkg::STATUS_PLACED) ?
                              ffipa_pkg::PLANE_OUT_W'(plane_reg) : '0;
            out_status_reg <= cmd.code;
            out_used_reg   <= ffipa_pkg::USED_OUT_W'(used_reg);
        end
    end

    ffipa_ram #(
        .WIDTH (ffipa_pkg::WORD_BITS),
        .DEPTH (OCC_DEPTH)
    ) u_occ_ram (
        .clk     (clk),
        .we      (occ_we),
        .wr_addr (occ_wr_addr),
        .wr_data (occ_wr_data),
        .rd_addr (occ_rd_addr),
        .rd_data (occ_rd_data)
    );

    ffipa_ram #(
        .WIDTH (ffipa_pkg::TAG_W),
        .DEPTH (STR_DEPTH)
    ) u_strand_ram (
        .clk     (clk),
        .we      (str_we),
        .wr_addr (str_wr_addr),
        .wr_data (str_wr_data),
        .rd_addr (str_place_addr),
        .rd_data (str_rd_data)
    );

    assign out_valid     = out_valid_reg;
    assign plane_index   = out_plane_reg;
    assign status        = out_status_reg;
    assign planes_in_use = out_used_reg;

    // strand entry written at mark start reads back through the RAM's registered read port
    a_strand_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.mark_start, 2) |-> str_rd_data == tag_reg)
        else $error("strand entry readback mismatch");

    a_placed_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.code == ffipa_pkg::STATUS_PLACED) |-> UW'(plane_reg) < used_reg)
        else $error("placed plane not counted as in use");

endmodule

`default_nettype wire

// ===== rtl/first_fit_interval_plane_assign.sv =====
// Flow: a bad range goes straight from the test to the result; otherwise planes are
//   scanned first fit, 64-bit word by word over the range, and a free plane gets a mark
//   pass before the result, while no free plane ends once the last plane is scanned.
// Throughput: one item at a time, bound by the single read port of the occupancy RAM.
// Reset: async active low; then a clearing pass over every occupancy and strand entry
//   during which in_stall stays high.
`default_nettype none

module first_fit_interval_plane_assign #(
    parameter int NUM_PLANES    = 16,
    parameter int NUM_POSITIONS = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [ffipa_pkg::POS_W-1:0]          first_pos,
    input  wire logic [ffipa_pkg::POS_W-1:0]          end_pos,
    input  wire logic [ffipa_pkg::TAG_W-1:0]          strand_tag,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [ffipa_pkg::PLANE_OUT_W-1:0]         plane_index,
    output logic [1:0]                                status,
    output logic [ffipa_pkg::USED_OUT_W-1:0]          planes_in_use
);

    ffipa_pkg::cmd_t cmd;
    ffipa_pkg::sts_t sts;

    ffipa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffipa_dp #(
        .NUM_PLANES    (NUM_PLANES),
        .NUM_POSITIONS (NUM_POSITIONS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .first_pos     (first_pos),
        .end_pos       (end_pos),
        .strand_tag    (strand_tag),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .plane_index   (plane_index),
        .status        (status),
        .planes_in_use (planes_in_use)
    );

endmodule

`default_nettype wire
